[design/bcpp_pkg.sv]
// Shared types, codes and literal tables of the bracket command packet parser.
`default_nettype none
package bcpp_pkg;

    localparam int PACKET_CAPACITY = 96;
    localparam int ADDR_W = $clog2(PACKET_CAPACITY);

    // Result status codes
    localparam logic [3:0] STS_IGNORED    = 4'd0;
    localparam logic [3:0] STS_STORED     = 4'd1;
    localparam logic [3:0] STS_START      = 4'd2;
    localparam logic [3:0] STS_RESYNC     = 4'd3;
    localparam logic [3:0] STS_OVERFLOW   = 4'd4;
    localparam logic [3:0] STS_TIMEOUT    = 4'd5;
    localparam logic [3:0] STS_FORMAT     = 4'd6;
    localparam logic [3:0] STS_UNKNOWN    = 4'd7;
    localparam logic [3:0] STS_REJECTED   = 4'd8;
    localparam logic [3:0] STS_KEY_DONE   = 4'd9;
    localparam logic [3:0] STS_SLIDER_DONE = 4'd10;

    // Action codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_SELECT   = 3'd1;
    localparam logic [2:0] ACT_REFRESH  = 3'd2;
    localparam logic [2:0] ACT_PLOT     = 3'd3;
    localparam logic [2:0] ACT_RESET    = 3'd4;
    localparam logic [2:0] ACT_SET_GAIN = 3'd5;

    // Gain selects
    localparam logic [1:0] GAIN_KP = 2'd0;
    localparam logic [1:0] GAIN_KI = 2'd1;
    localparam logic [1:0] GAIN_KD = 2'd2;

    // Loop indexes
    localparam logic [1:0] LOOP_LINE  = 2'd0;
    localparam logic [1:0] LOOP_YAW   = 2'd1;
    localparam logic [1:0] LOOP_LEFT  = 2'd2;
    localparam logic [1:0] LOOP_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [1:0] CFG_GAIN_MAX     = 2'd1;
    localparam logic [1:0] CFG_PLOT_DEFAULT = 2'd2;

    localparam logic [15:0] TIMEOUT_RST  = 16'd100;
    localparam logic [31:0] GAIN_MAX_RST = 32'd6553600;
    localparam logic        PLOT_RST     = 1'b0;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // floor(v / 10) = (v * RECIP10) >> RECIP_SHIFT for v below 2^22
    localparam logic [19:0] RECIP10     = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    // Field literals, lower case
    localparam int NUM_LIT = 24;
    localparam int L_KEY = 0, L_SLIDER = 1, L_SLIDE = 2, L_1 = 3, L_LINE = 4, L_2 = 5,
        L_YAW = 6, L_3 = 7, L_LEFT = 8, L_4 = 9, L_RIGHT = 10, L_5 = 11, L_STATUS = 12,
        L_6 = 13, L_PLOT = 14, L_7 = 15, L_RESET = 16, L_KP = 17, L_KI = 18, L_KD = 19,
        L_UP = 20, L_DOWN = 21, L_CLICK = 22, L_PRESS = 23;

    localparam logic [2:0] LIT_LEN [NUM_LIT] = '{
        3'd3, 3'd6, 3'd5, 3'd1, 3'd4, 3'd1, 3'd3, 3'd1, 3'd4, 3'd1, 3'd5, 3'd1,
        3'd6, 3'd1, 3'd4, 3'd1, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd5, 3'd5
    };

    localparam logic [7:0] LIT_CHR [NUM_LIT][8] = '{
        '{"k", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "l", "i", "d", "e", "r", 8'h00, 8'h00},
        '{"s", "l", "i", "d", "e", 8'h00, 8'h00, 8'h00},
        '{"1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "i", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"y", "a", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"3", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", "f", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"4", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "i", "g", "h", "t", 8'h00, 8'h00, 8'h00},
        '{"5", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "a", "t", "u", "s", 8'h00, 8'h00},
        '{"6", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "l", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"7", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "s", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"k", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"k", "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"k", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", "w", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "l", "i", "c", "k", 8'h00, 8'h00, 8'h00},
        '{"p", "r", "e", "s", "s", 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CH,
        S_FRAC_RD,
        S_FRAC_CH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_init;
        logic rd;
        logic ch;
        logic fin_scan;
        logic frac_rd;
        logic frac_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_parse;
        logic scan_end;
        logic frac_end;
    } t_dp_stat;

    function automatic logic [7:0] lower_ch(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/bcpp_ifs.sv]
// Request channel interfaces: input items, result items and configuration writes.
`default_nettype none
interface bcpp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    modport source(output valid, command, rx_byte, now_ms, input ready);
    modport sink(input valid, command, rx_byte, now_ms, output ready);
endinterface

interface bcpp_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  status;
    logic [2:0]  action;
    logic [1:0]  loop_index;
    logic [1:0]  gain_select;
    logic [31:0] gain_value;
    logic        plot_on;
    modport source(output valid, accepted, status, action, loop_index, gain_select,
                   gain_value, plot_on, input ready);
    modport sink(input valid, accepted, status, action, loop_index, gain_select,
                 gain_value, plot_on, output ready);
endinterface

interface bcpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/bracket_command_packet_parser.sv]
// Top level of the bracket command packet parser: controller, datapath and assertions.
// A received byte or a timeout check is loaded straight into the result register.
// A closing ']' of a held packet starts a scan of the packet text memory, whose single
// read port with registered data gives each stored character a read state and a check
// state. The scan reads n characters (all stored ones, or those up to and including the
// first zero byte; at most 95); a second pass then reads the f fraction digits of the
// value field and folds them last digit first.
// A new request is taken in the idle state once the result register is free or being
// emptied; configuration writes are taken in every cycle.
`default_nettype none
module bracket_command_packet_parser (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bcpp_in_if.sink     i_in_ch,
    bcpp_out_if.source  o_out_ch,
    bcpp_cfg_if.sink    i_cfg_ch
);
    import bcpp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg_ch.ready = 1'b1;

    bcpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid)
    );

    bcpp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_command     (i_in_ch.command),
        .i_rx_byte     (i_in_ch.rx_byte),
        .i_now_ms      (i_in_ch.now_ms),
        .i_cfg_we      (i_cfg_ch.valid),
        .i_cfg_index   (i_cfg_ch.index),
        .i_cfg_data    (i_cfg_ch.data),
        .o_accepted    (o_out_ch.accepted),
        .o_status      (o_out_ch.status),
        .o_action      (o_out_ch.action),
        .o_loop_index  (o_out_ch.loop_index),
        .o_gain_select (o_out_ch.gain_select),
        .o_gain_value  (o_out_ch.gain_value),
        .o_plot_on     (o_out_ch.plot_on)
    );

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.ready |-> (!o_out_ch.valid || o_out_ch.ready))
        else $error("request taken while result register is full");

    a_slider_sets_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.status == STS_SLIDER_DONE)
        |-> (o_out_ch.action == ACT_SET_GAIN))
        else $error("slider done without set gain action");

    a_gain_zero_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.action != ACT_SET_GAIN)
        |-> (o_out_ch.gain_value == 32'd0 && o_out_ch.gain_select == GAIN_KP))
        else $error("gain fields set without set gain action");

    a_timeout_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready && i_in_ch.command)
        |=> (o_out_ch.valid && !o_out_ch.accepted))
        else $error("timeout check reported as consumed byte");

endmodule
`default_nettype wire

[design/bcpp_ctrl.sv]
// Controller state machine: request handshakes and sequencing of the packet scan.
`default_nettype none
module bcpp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_ready,
    input  wire bcpp_pkg::t_dp_stat i_stat,
    output bcpp_pkg::t_dp_cmd       o_cmd,
    output logic                    o_in_ready,
    output logic                    o_out_valid
);
    import bcpp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.need_parse) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN_RD;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.fin_scan = 1'b1;
                    n_state        = S_FRAC_RD;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_SCAN_CH;
                end
            end
            S_SCAN_CH: begin
                o_cmd.ch = 1'b1;
                n_state  = S_SCAN_RD;
            end
            S_FRAC_RD: begin
                if (i_stat.frac_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.frac_rd = 1'b1;
                    n_state       = S_FRAC_CH;
                end
            end
            S_FRAC_CH: begin
                o_cmd.frac_step = 1'b1;
                n_state         = S_FRAC_RD;
            end
            S_FINISH: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[design/bcpp_datapath.sv]
// Datapath: framing state, packet text memory, field matcher, decimal parser, result register.
`default_nettype none
module bcpp_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bcpp_pkg::t_dp_cmd i_cmd,
    output bcpp_pkg::t_dp_stat     o_stat,
    input  wire logic              i_command,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output logic                   o_accepted,
    output logic [3:0]             o_status,
    output logic [2:0]             o_action,
    output logic [1:0]             o_loop_index,
    output logic [1:0]             o_gain_select,
    output logic [31:0]            o_gain_value,
    output logic                   o_plot_on
);
    import bcpp_pkg::*;

    logic [7:0]  r_mem [PACKET_CAPACITY];
    logic [7:0]  r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    logic [15:0] r_timeout;
    logic [31:0] r_gain_max;
    logic [ADDR_W-1:0] r_tl;
    logic        r_in_pkt, r_drop;
    logic [31:0] r_last;
    logic [1:0]  r_loop;
    logic        r_plot;

    // scan state
    logic [ADDR_W-1:0] r_addr, r_caddr, r_pos, r_flen, r_fs, r_fe, r_faddr;
    logic        r_stop;
    logic [1:0]  r_fidx, r_cnt;
    logic        r_started, r_blank, r_inter, r_empty0;
    logic [NUM_LIT-1:0] r_ok, r_m0, r_m1, r_m2;
    logic        r_nphase, r_nbad, r_have, r_nz, r_neg;
    logic [31:0] r_ip;
    logic [15:0] r_frac;

    // framing results
    logic        fr_acc, fr_in, fr_drop, fr_parse, fr_wr;
    logic [3:0]  fr_status;
    logic [ADDR_W-1:0] fr_tl;
    logic [31:0] fr_last, elapsed;

    // character classification
    logic [7:0]  lc;
    logic        c_blank, c_digit;
    logic [3:0]  c_val;
    logic [NUM_LIT-1:0] ok_next, fmatch;
    logic [35:0] ip10;
    logic [19:0] frac_v;
    logic [39:0] frac_prod;

    // packet decision
    logic [3:0]  dec_status;
    logic [2:0]  dec_action;
    logic [1:0]  dec_gsel, dec_loop;
    logic        dec_plot, gain_ok;
    logic [32:0] total;

    always_comb begin
        elapsed   = i_now_ms - r_last;
        fr_acc    = 1'b0;
        fr_status = STS_IGNORED;
        fr_in     = r_in_pkt;
        fr_drop   = r_drop;
        fr_tl     = r_tl;
        fr_last   = r_last;
        fr_parse  = 1'b0;
        fr_wr     = 1'b0;
        if (i_command) begin
            if (r_in_pkt && elapsed > {16'd0, r_timeout}) begin
                fr_in     = 1'b0;
                fr_drop   = 1'b0;
                fr_tl     = '0;
                fr_status = STS_TIMEOUT;
            end
        end else if (!r_in_pkt) begin
            if (i_rx_byte == CH_LBRACK) begin
                fr_in     = 1'b1;
                fr_drop   = 1'b0;
                fr_tl     = '0;
                fr_last   = i_now_ms;
                fr_acc    = 1'b1;
                fr_status = STS_START;
            end
        end else begin
            fr_acc  = 1'b1;
            fr_last = i_now_ms;
            if (i_rx_byte == CH_LBRACK) begin
                fr_drop   = 1'b0;
                fr_tl     = '0;
                fr_status = STS_RESYNC;
            end else if (i_rx_byte == CH_RBRACK) begin
                fr_in   = 1'b0;
                fr_drop = 1'b0;
                if (r_drop) begin
                    fr_tl     = '0;
                    fr_status = STS_OVERFLOW;
                end else begin
                    // keep the text length for the scan
                    fr_parse = 1'b1;
                end
            end else if (r_drop) begin
                fr_status = STS_OVERFLOW;
            end else if (r_tl < ADDR_W'(PACKET_CAPACITY - 1)) begin
                fr_wr     = 1'b1;
                fr_tl     = r_tl + 1'b1;
                fr_status = STS_STORED;
            end else begin
                fr_drop   = 1'b1;
                fr_status = STS_OVERFLOW;
            end
        end
    end

    assign o_stat.need_parse = fr_parse;
    assign o_stat.scan_end   = (r_addr == r_tl) || r_stop;
    assign o_stat.frac_end   = (r_faddr <= r_fs);

    always_comb begin
        lc      = lower_ch(r_rd_data);
        c_blank = (r_rd_data == CH_SPACE) || (r_rd_data == CH_TAB);
        c_digit = r_rd_data inside {[8'h30:8'h39]};
        c_val   = r_rd_data[3:0];
        for (int k = 0; k < NUM_LIT; k++) begin
            ok_next[k] = r_ok[k] && (r_pos < ADDR_W'(LIT_LEN[k]))
                && (lc == LIT_CHR[k][r_pos[2:0]]);
            fmatch[k]  = r_ok[k] && !r_inter && (r_flen == ADDR_W'(LIT_LEN[k]));
        end
        ip10      = {r_ip, 3'b000} + {3'b000, r_ip, 1'b0} + {16'd0, c_val, 16'd0};
        frac_v    = {c_val, r_frac};
        frac_prod = frac_v * RECIP10;
    end

    always_comb begin
        total      = {1'b0, r_ip} + {17'd0, r_frac};
        gain_ok    = (r_cnt == 2'd3) && r_have && !r_nbad && !(r_neg && r_nz)
            && (total <= {1'b0, r_gain_max});
        dec_status = STS_UNKNOWN;
        dec_action = ACT_NONE;
        dec_gsel   = GAIN_KP;
        dec_loop   = r_loop;
        dec_plot   = r_plot;
        if (r_empty0) begin
            dec_status = STS_FORMAT;
        end else if (r_m0[L_KEY]) begin
            if (r_cnt != 2'd3) begin
                dec_status = STS_FORMAT;
            end else if (!(r_m2[L_UP] || r_m2[L_DOWN] || r_m2[L_CLICK] || r_m2[L_PRESS]))
            begin
                dec_status = STS_FORMAT;
            end else begin
                dec_status = STS_KEY_DONE;
                if (r_m1[L_1] || r_m1[L_LINE]) begin
                    dec_loop = LOOP_LINE;  dec_action = ACT_SELECT;
                end else if (r_m1[L_2] || r_m1[L_YAW]) begin
                    dec_loop = LOOP_YAW;   dec_action = ACT_SELECT;
                end else if (r_m1[L_3] || r_m1[L_LEFT]) begin
                    dec_loop = LOOP_LEFT;  dec_action = ACT_SELECT;
                end else if (r_m1[L_4] || r_m1[L_RIGHT]) begin
                    dec_loop = LOOP_RIGHT; dec_action = ACT_SELECT;
                end else if (r_m1[L_5] || r_m1[L_STATUS]) begin
                    dec_action = ACT_REFRESH;
                end else if (r_m1[L_6] || r_m1[L_PLOT]) begin
                    dec_plot = !r_plot;    dec_action = ACT_PLOT;
                end else if (r_m1[L_7] || r_m1[L_RESET]) begin
                    dec_action = ACT_RESET;
                end else begin
                    dec_status = STS_UNKNOWN;
                end
            end
        end else if (r_m0[L_SLIDER] || r_m0[L_SLIDE]) begin
            // the value is checked before the name
            if (!gain_ok) begin
                dec_status = STS_REJECTED;
            end else begin
                dec_status = STS_SLIDER_DONE;
                dec_action = ACT_SET_GAIN;
                if (r_m1[L_1] || r_m1[L_KP]) begin
                    dec_gsel = GAIN_KP;
                end else if (r_m1[L_2] || r_m1[L_KI]) begin
                    dec_gsel = GAIN_KI;
                end else if (r_m1[L_3] || r_m1[L_KD]) begin
                    dec_gsel = GAIN_KD;
                end else begin
                    dec_status = STS_UNKNOWN;
                    dec_action = ACT_NONE;
                end
            end
        end
    end

    assign rd_addr = i_cmd.frac_rd ? (r_faddr - 1'b1) : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && fr_wr) begin
            r_mem[r_tl] <= i_rx_byte;
        end
        if (i_cmd.rd || i_cmd.frac_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control and framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_gain_max <= GAIN_MAX_RST;
            r_tl       <= '0;
            r_in_pkt   <= 1'b0;
            r_drop     <= 1'b0;
            r_last     <= '0;
            r_loop     <= LOOP_LINE;
            r_plot     <= PLOT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                    CFG_GAIN_MAX: r_gain_max <= i_cfg_data;
                    // the plot default write is ignored; reset restores the fixed reset value
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_tl     <= fr_tl;
                r_in_pkt <= fr_in;
                r_drop   <= fr_drop;
                r_last   <= fr_last;
            end
            if (i_cmd.finish) begin
                r_tl   <= '0;
                r_loop <= dec_loop;
                r_plot <= dec_plot;
            end
        end
    end

    // scan state and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_addr    <= '0;
            r_stop    <= 1'b0;
            r_fidx    <= 2'd0;
            r_cnt     <= 2'd1;
            r_started <= 1'b0;
            r_blank   <= 1'b0;
            r_inter   <= 1'b0;
            r_pos     <= '0;
            r_flen    <= '0;
            r_ok      <= '1;
            r_m0      <= '0;
            r_m1      <= '0;
            r_m2      <= '0;
            r_empty0  <= 1'b1;
            r_nphase  <= 1'b0;
            r_nbad    <= 1'b0;
            r_have    <= 1'b0;
            r_nz      <= 1'b0;
            r_neg     <= 1'b0;
            r_ip      <= '0;
            r_fs      <= '0;
            r_fe      <= '0;
            r_frac    <= '0;
        end
        if (i_cmd.rd) begin
            r_caddr <= r_addr;
            r_addr  <= r_addr + 1'b1;
        end
        if (i_cmd.ch) begin
            if (r_rd_data == CH_NUL) begin
                r_stop <= 1'b1;
            end else if (r_fidx != 2'd3) begin
                if (r_rd_data == CH_COMMA) begin
                    case (r_fidx)
                        2'd0: begin
                            r_m0     <= fmatch;
                            r_empty0 <= (r_flen == '0);
                            r_cnt    <= 2'd2;
                        end
                        2'd1: begin
                            r_m1  <= fmatch;
                            r_cnt <= 2'd3;
                        end
                        default: r_m2 <= fmatch;
                    endcase
                    r_fidx    <= r_fidx + 1'b1;
                    r_started <= 1'b0;
                    r_blank   <= 1'b0;
                    r_inter   <= 1'b0;
                    r_pos     <= '0;
                    r_flen    <= '0;
                    r_ok      <= '1;
                end else if (c_blank) begin
                    if (r_started) begin
                        r_pos   <= r_pos + 1'b1;
                        r_blank <= 1'b1;
                    end
                end else begin
                    if (r_blank) begin
                        r_inter <= 1'b1;
                    end
                    r_blank   <= 1'b0;
                    r_ok      <= ok_next;
                    r_started <= 1'b1;
                    r_pos     <= r_pos + 1'b1;
                    r_flen    <= r_pos + 1'b1;
                    if (r_fidx == 2'd2) begin
                        if (r_blank) begin
                            r_nbad <= 1'b1;
                        end
                        if (!r_started &&
                            (r_rd_data == CH_PLUS || r_rd_data == CH_MINUS)) begin
                            r_neg <= (r_rd_data == CH_MINUS);
                        end else if (c_digit && !r_nphase) begin
                            r_have <= 1'b1;
                            if (c_val != 4'd0) r_nz <= 1'b1;
                            if (ip10 > {4'd0, r_gain_max}) begin
                                r_nbad <= 1'b1;
                            end else begin
                                r_ip <= ip10[31:0];
                            end
                        end else if (r_rd_data == CH_DOT && !r_nphase) begin
                            r_nphase <= 1'b1;
                            r_fs     <= r_caddr + 1'b1;
                            r_fe     <= r_caddr + 1'b1;
                        end else if (c_digit && r_nphase) begin
                            r_have <= 1'b1;
                            if (c_val != 4'd0) r_nz <= 1'b1;
                            r_fe <= r_caddr + 1'b1;
                        end else begin
                            r_nbad <= 1'b1;
                        end
                    end
                end
            end
        end
        if (i_cmd.fin_scan) begin
            case (r_fidx)
                2'd0: begin
                    r_m0     <= fmatch;
                    r_empty0 <= (r_flen == '0);
                end
                2'd1: r_m1 <= fmatch;
                2'd2: r_m2 <= fmatch;
                default: ;
            endcase
            r_faddr <= r_fe;
        end
        if (i_cmd.frac_rd) begin
            r_faddr <= r_faddr - 1'b1;
        end
        if (i_cmd.frac_step) begin
            // fold one fraction digit, last digit first
            r_frac <= frac_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        end
        if (i_cmd.accept) begin
            o_accepted    <= fr_acc;
            o_status      <= fr_status;
            o_action      <= ACT_NONE;
            o_loop_index  <= r_loop;
            o_gain_select <= GAIN_KP;
            o_gain_value  <= '0;
            o_plot_on     <= r_plot;
        end
        if (i_cmd.finish) begin
            o_accepted    <= 1'b1;
            o_status      <= dec_status;
            o_action      <= dec_action;
            o_loop_index  <= dec_loop;
            o_gain_select <= (dec_action == ACT_SET_GAIN) ? dec_gsel : GAIN_KP;
            o_gain_value  <= (dec_action == ACT_SET_GAIN) ? total[31:0] : 32'd0;
            o_plot_on     <= dec_plot;
        end
    end

endmodule
`default_nettype wire

[verif/tb_bracket_command_packet_parser.sv]
// Self-checking testbench for the bracket command packet parser.
`timescale 1ns / 100ps
module tb_bracket_command_packet_parser;
    import bcpp_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 235;

    typedef struct packed {
        logic        acc;
        logic [3:0]  sts;
        logic [2:0]  act;
        logic [1:0]  loop;
        logic [1:0]  gsel;
        logic [31:0] gval;
        logic        plot;
    } t_parse_result;

    typedef struct {
        bit            cmd;
        string         txt;
        logic [7:0]    raw;
        int            rep;
        int            dt;
        bit            typed;
        t_parse_result want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bcpp_in_if  in_ch();
    bcpp_out_if out_ch();
    bcpp_cfg_if cfg_ch();

    bracket_command_packet_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Parser state mirrored by the predictor
    logic [7:0]  m_text [PACKET_CAPACITY];
    int          m_len;
    bit          m_open;
    bit          m_drop;
    logic [31:0] m_last;
    logic [1:0]  m_loop;
    logic        m_plot;
    logic [15:0] r_timeout;
    logic [31:0] r_gain_max;
    logic        r_plot_dflt;
    int          f_start [3];
    int          f_len [3];
    int          f_cnt;

    t_parse_result pending_results[$];
    t_stim_row     dir_rows[$];
    logic [7:0]    pkt[$];
    logic [31:0]   t_now;
    int            items_sent;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            hold_left;
    int            idle_cycles;
    bit            failed;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit field_is(input int f, input string lit);
        if (f >= f_cnt || f_len[f] != lit.len()) begin
            return 0;
        end
        for (int i = 0; i < f_len[f]; i++) begin
            if (fold_case(m_text[f_start[f] + i]) != lit[i]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit field_either(input int f, input string a, input string b);
        return field_is(f, a) || field_is(f, b);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void split_fields(input int tlen);
        int pos;
        int s;
        int e;
        int t;
        pos = 0;
        f_cnt = 0;
        while (f_cnt < 3) begin
            s = pos;
            e = pos;
            while (e < tlen && m_text[e] != CH_COMMA) e++;
            while (s < e && is_blank(m_text[s])) s++;
            t = e;
            while (t > s && is_blank(m_text[t - 1])) t--;
            f_start[f_cnt] = s;
            f_len[f_cnt] = t - s;
            f_cnt++;
            if (e >= tlen) break;
            pos = e + 1;
        end
    endfunction

    // Decimal to unsigned Q16.16, fraction truncated, bounded by gain_max
    function automatic bit decimal_to_gain(input int f, output logic [31:0] v);
        int pos;
        int en;
        int fs;
        int fe;
        bit neg;
        bit have;
        bit nz;
        longint unsigned ip;
        longint unsigned frac;
        longint unsigned d;
        neg = 0;
        have = 0;
        nz = 0;
        ip = 0;
        frac = 0;
        v = '0;
        if (f >= f_cnt) return 0;
        pos = f_start[f];
        en = pos + f_len[f];
        if (pos < en && (m_text[pos] == CH_PLUS || m_text[pos] == CH_MINUS)) begin
            neg = m_text[pos] == CH_MINUS;
            pos++;
        end
        while (pos < en && is_digit(m_text[pos])) begin
            d = m_text[pos] - 8'h30;
            have = 1;
            if (d != 0) nz = 1;
            ip = ip * 10 + d * 65536;
            if (ip > r_gain_max) return 0;
            pos++;
        end
        fs = pos;
        fe = pos;
        if (pos < en && m_text[pos] == CH_DOT) begin
            pos++;
            fs = pos;
            while (pos < en && is_digit(m_text[pos])) begin
                have = 1;
                if (m_text[pos] != "0") nz = 1;
                pos++;
            end
            fe = pos;
        end
        if (!have || pos != en) return 0;
        while (fe > fs) begin
            fe--;
            frac = ((m_text[fe] - 8'h30) * 65536 + frac) / 10;
        end
        if (neg && nz) return 0;
        if (ip + frac > r_gain_max) return 0;
        v = ip + frac;
        return 1;
    endfunction

    function automatic logic [3:0] decode_packet(output logic [2:0] act,
                                                 output logic [1:0] gsel,
                                                 output logic [31:0] gval);
        int tlen;
        logic [31:0] v;
        act = ACT_NONE;
        gsel = GAIN_KP;
        gval = '0;
        tlen = 0;
        while (tlen < m_len && m_text[tlen] != CH_NUL) tlen++;
        split_fields(tlen);
        if (f_len[0] == 0) return STS_FORMAT;
        if (field_is(0, "key")) begin
            if (f_cnt < 3) return STS_FORMAT;
            if (!(field_is(2, "up") || field_is(2, "down") || field_is(2, "click") ||
                  field_is(2, "press"))) return STS_FORMAT;
            if (field_either(1, "1", "line")) begin
                m_loop = LOOP_LINE;
                act = ACT_SELECT;
            end else if (field_either(1, "2", "yaw")) begin
                m_loop = LOOP_YAW;
                act = ACT_SELECT;
            end else if (field_either(1, "3", "left")) begin
                m_loop = LOOP_LEFT;
                act = ACT_SELECT;
            end else if (field_either(1, "4", "right")) begin
                m_loop = LOOP_RIGHT;
                act = ACT_SELECT;
            end else if (field_either(1, "5", "status")) begin
                act = ACT_REFRESH;
            end else if (field_either(1, "6", "plot")) begin
                m_plot = !m_plot;
                act = ACT_PLOT;
            end else if (field_either(1, "7", "reset")) begin
                act = ACT_RESET;
            end else begin
                return STS_UNKNOWN;
            end
            return STS_KEY_DONE;
        end
        if (field_either(0, "slider", "slide")) begin
            if (f_cnt < 2 || !decimal_to_gain(2, v)) return STS_REJECTED;
            if (field_either(1, "1", "kp")) gsel = GAIN_KP;
            else if (field_either(1, "2", "ki")) gsel = GAIN_KI;
            else if (field_either(1, "3", "kd")) gsel = GAIN_KD;
            else return STS_UNKNOWN;
            act = ACT_SET_GAIN;
            gval = v;
            return STS_SLIDER_DONE;
        end
        return STS_UNKNOWN;
    endfunction

    function automatic t_parse_result predict_parser_result(input bit cmd,
                                                            input logic [7:0] b,
                                                            input logic [31:0] now);
        t_parse_result r;
        logic [31:0] age;
        r = '0;
        age = now - m_last;
        if (cmd) begin
            if (m_open && age > {16'd0, r_timeout}) begin
                m_open = 0;
                m_drop = 0;
                m_len = 0;
                r.sts = STS_TIMEOUT;
            end
        end else if (!m_open) begin
            if (b == CH_LBRACK) begin
                m_open = 1;
                m_drop = 0;
                m_len = 0;
                m_last = now;
                r.acc = 1;
                r.sts = STS_START;
            end
        end else begin
            r.acc = 1;
            m_last = now;
            if (b == CH_LBRACK) begin
                m_drop = 0;
                m_len = 0;
                r.sts = STS_RESYNC;
            end else if (b == CH_RBRACK) begin
                if (m_drop) r.sts = STS_OVERFLOW;
                else r.sts = decode_packet(r.act, r.gsel, r.gval);
                m_open = 0;
                m_drop = 0;
                m_len = 0;
            end else if (m_drop) begin
                r.sts = STS_OVERFLOW;
            end else if (m_len < PACKET_CAPACITY - 1) begin
                m_text[m_len] = b;
                m_len++;
                r.sts = STS_STORED;
            end else begin
                m_drop = 1;
                r.sts = STS_OVERFLOW;
            end
        end
        r.loop = m_loop;
        r.plot = m_plot;
        return r;
    endfunction

    task automatic send_item(input bit cmd, input logic [7:0] b, input int unsigned dt,
                             input bit typed, input t_parse_result want);
        t_parse_result r;
        t_now = t_now + dt;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_byte <= b;
        in_ch.now_ms  <= t_now;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_parser_result(cmd, b, t_now);
        if (typed) begin
            r.acc  = want.acc;
            r.sts  = want.sts;
            r.act  = want.act;
            r.gsel = want.gsel;
            r.gval = want.gval;
        end
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic send_packet(input int unsigned dtmax);
        for (int i = 0; i < pkt.size(); i++) begin
            send_item(1'b0, pkt[i], $urandom_range(0, dtmax), 1'b0, '0);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_TIMEOUT:      r_timeout = val[15:0];
            CFG_GAIN_MAX:     r_gain_max = val;
            CFG_PLOT_DEFAULT: r_plot_dflt = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] tmo, input logic [31:0] gmax, input logic pd);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_write(CFG_TIMEOUT, {16'd0, tmo});
        cfg_write(CFG_GAIN_MAX, gmax);
        cfg_write(CFG_PLOT_DEFAULT, {31'd0, pd});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add_row(input bit cmd, input string txt, input logic [7:0] raw,
                                    input int rep, input int dt, input bit typed,
                                    input logic acc, input logic [3:0] sts,
                                    input logic [2:0] act, input logic [1:0] gsel,
                                    input logic [31:0] gval);
        t_stim_row row;
        row.cmd = cmd;
        row.txt = txt;
        row.raw = raw;
        row.rep = rep;
        row.dt = dt;
        row.typed = typed;
        row.want = '0;
        row.want.acc = acc;
        row.want.sts = sts;
        row.want.act = act;
        row.want.gsel = gsel;
        row.want.gval = gval;
        dir_rows.push_back(row);
    endfunction

    // Append text with random letter case
    function automatic void add_text(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
            pkt.push_back(c);
        end
    endfunction

    function automatic void add_pad();
        repeat ($urandom_range(0, 2)) pkt.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_field(input string s);
        add_pad();
        add_text(s);
        add_pad();
    endfunction

    function automatic string random_decimal();
        string s;
        int n;
        s = "";
        n = $urandom_range(99);
        if (n < 8) s = "-";
        else if (n < 14) s = "+";
        n = $urandom_range(99);
        if (n < 60) s = {s, $sformatf("%0d", $urandom_range(0, 120))};
        else if (n < 75) s = {s, $sformatf("%0d", $urandom_range(0, 99999))};
        else if (n < 85) s = {s, "0"};
        if ($urandom_range(99) < 60) begin
            s = {s, "."};
            repeat ($urandom_range(0, 8)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(99) < 5) s = {s, "x"};
        return s;
    endfunction

    function automatic void build_command_packet(input bit is_key);
        string key_names[17] = '{"1", "line", "2", "yaw", "3", "left", "4", "right", "5",
                                 "status", "6", "plot", "7", "reset", "8", "lin", "keys"};
        string key_acts[6] = '{"up", "down", "click", "press", "hold", ""};
        string sl_tags[3] = '{"slider", "slide", "slid"};
        string sl_names[8] = '{"1", "kp", "2", "ki", "3", "kd", "k", "4"};
        pkt.delete();
        pkt.push_back(CH_LBRACK);
        if (is_key) begin
            add_field($urandom_range(99) < 92 ? "key" : "ke");
            pkt.push_back(CH_COMMA);
            add_field(key_names[$urandom_range(99) < 85 ? $urandom_range(0, 13) :
                                                          $urandom_range(14, 16)]);
            if ($urandom_range(99) < 93) begin
                pkt.push_back(CH_COMMA);
                add_field(key_acts[$urandom_range(99) < 85 ? $urandom_range(0, 3) :
                                                             $urandom_range(4, 5)]);
            end
        end else begin
            add_field(sl_tags[$urandom_range(99) < 92 ? $urandom_range(0, 1) : 2]);
            if ($urandom_range(99) < 95) begin
                pkt.push_back(CH_COMMA);
                add_field(sl_names[$urandom_range(99) < 88 ? $urandom_range(0, 5) :
                                                             $urandom_range(6, 7)]);
                if ($urandom_range(99) < 95) begin
                    pkt.push_back(CH_COMMA);
                    add_field(random_decimal());
                end
            end
        end
        if ($urandom_range(99) < 8) begin
            pkt.push_back(CH_COMMA);
            add_field("extra");
        end
        // drop a terminator somewhere in the text now and then
        if ($urandom_range(99) < 5) pkt.insert($urandom_range(1, pkt.size() - 1), CH_NUL);
        pkt.push_back(CH_RBRACK);
    endfunction

    task automatic send_random_unit();
        int kind;
        kind = $urandom_range(99);
        if (kind < 40) begin
            build_command_packet(1'b1);
            send_packet(20);
        end else if (kind < 70) begin
            build_command_packet(1'b0);
            send_packet(20);
        end else if (kind < 75) begin
            pkt.delete();
            pkt.push_back(CH_LBRACK);
            repeat ($urandom_range(PACKET_CAPACITY - 3, PACKET_CAPACITY + 4)) begin
                pkt.push_back($urandom_range(1) ? "a" : ",");
            end
            pkt.push_back(CH_RBRACK);
            send_packet(3);
        end else if (kind < 80) begin
            pkt.delete();
            add_text("[key,");
            send_packet(10);
            send_item(1'b1, $urandom_range(0, 255), r_timeout + $urandom_range(0, 2), 1'b0, '0);
        end else if (kind < 88) begin
            t_now = $urandom();
            repeat ($urandom_range(1, 8)) begin
                send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 40), 1'b0, '0);
            end
        end else if (kind < 95) begin
            send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 150), 1'b0, '0);
        end else begin
            build_command_packet($urandom_range(1));
            pkt.insert(0, "x");
            pkt.insert(0, CH_LBRACK);
            send_packet(20);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failed = 1;
        end
    endtask

    // Result checker and receiver ready, with long hold-offs on request
    always @(posedge i_clk) begin
        t_parse_result w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result received with no request pending");
                failed = 1;
            end else begin
                w = pending_results.pop_front();
                check_field("accepted", w.acc, out_ch.accepted);
                check_field("status", w.sts, out_ch.status);
                check_field("action", w.act, out_ch.action);
                check_field("loop_index", w.loop, out_ch.loop_index);
                check_field("gain_select", w.gsel, out_ch.gain_select);
                check_field("gain_value", w.gval, out_ch.gain_value);
                check_field("plot_on", w.plot, out_ch.plot_on);
            end
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim_row row;
        int start;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = 1'b0;
        in_ch.rx_byte = '0;
        in_ch.now_ms = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        failed = 0;
        hold_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 68;
        t_now = 32'd1000;
        r_timeout = TIMEOUT_RST;
        r_gain_max = GAIN_MAX_RST;
        r_plot_dflt = PLOT_RST;
        foreach (m_text[i]) m_text[i] = '0;
        m_len = 0;
        m_open = 0;
        m_drop = 0;
        m_last = '0;
        m_loop = LOOP_LINE;
        m_plot = PLOT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(0, "", "x", 1, 1, 1, 0, STS_IGNORED, ACT_NONE, GAIN_KP, 0);
        add_row(0, "[key,1,up", 0, 1, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 1, 1, 1, STS_KEY_DONE, ACT_SELECT, GAIN_KP, 0);
        add_row(0, "[KEY, Right ,\tDown]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[key,6,click]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[key,status,press]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[key,reset,up]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[key,9,up]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[key,1", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 2, 1, 1, STS_FORMAT, ACT_NONE, GAIN_KP, 0);
        add_row(0, "[key,1,hold][][ ,x][foo,1]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[slider,kp,100", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 2, 1, 1, STS_SLIDER_DONE, ACT_SET_GAIN, GAIN_KP, 6553600);
        add_row(0, "[slide,KD,0.5", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 2, 1, 1, STS_SLIDER_DONE, ACT_SET_GAIN, GAIN_KD, 32768);
        add_row(0, "[slider,ki,100.0001", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 2, 1, 1, STS_REJECTED, ACT_NONE, GAIN_KP, 0);
        add_row(0, "[slider,kp,-0][slider,kp,-1][slider,kp,.][slider,x,1]", 0, 1, 2, 0,
                0, 0, 0, 0, 0);
        add_row(0, "[slider,1,1,junk][slider,3,99.99999999][ab[key,2,up]", 0, 1, 2, 0,
                0, 0, 0, 0, 0);
        add_row(0, "[key,4", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "", CH_NUL, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, ",up]", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "[", 0, 1, 2, 0, 0, 0, 0, 0, 0);
        add_row(0, "a", 0, PACKET_CAPACITY, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, "]", 0, 1, 1, 1, 1, STS_OVERFLOW, ACT_NONE, GAIN_KP, 0);
        add_row(0, "[key", 0, 1, 1, 0, 0, 0, 0, 0, 0);
        add_row(1, "", 8'hFF, 1, 100, 1, 0, STS_IGNORED, ACT_NONE, GAIN_KP, 0);
        add_row(1, "", 8'h00, 1, 1, 1, 0, STS_TIMEOUT, ACT_NONE, GAIN_KP, 0);
        add_row(0, "", CH_RBRACK, 1, 1, 1, 0, STS_IGNORED, ACT_NONE, GAIN_KP, 0);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            repeat (row.rep) begin
                if (row.txt.len() == 0) begin
                    send_item(row.cmd, row.raw, row.dt, row.typed, row.want);
                end else begin
                    for (int i = 0; i < row.txt.len(); i++) begin
                        send_item(row.cmd, row.txt[i], row.dt,
                                  row.typed && i == row.txt.len() - 1, row.want);
                    end
                end
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_config(16'd30, 32'hFFFF_FFFF, 1'b1);
                1: set_config(16'd0, 32'd0, 1'b0);
                default: set_config(16'hFFFF, 32'd13107200, 1'b1);
            endcase
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 68 : 0;
            rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 10 : 0;
            if (ph == 2) t_now = 32'hFFFF_F000;
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                send_random_unit();
                // stall the result side so the input backs up
                if (ph == 0 && items_sent - start >= 60 && items_sent - start < 80 &&
                    hold_left == 0) begin
                    hold_left = HOLD_CYCLES;
                end
                // pause the sender until all results are in
                if (ph == 2 && items_sent - start >= 150 && items_sent - start < 170) begin
                    in_ch.valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
        if (!failed) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
